// ----- rtl/csid_pkg.sv -----
// Shared types and constants for the compacting id set.
// Used by every module of the block; depends on nothing else.
package csid_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_W     = 16;
   localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int OCC_OUT_W = 7;

   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] key_id;
   } req_type;

   typedef struct packed {
      logic                 was_present;
      logic [1:0]           status;
      logic [OCC_OUT_W-1:0] occupancy_out;
   } rsp_type;

   // Flags from the shared compare/increment unit to the sequencer.
   typedef struct packed {
      logic             hit;
      logic             at_end;
      logic             last;
      logic [CNT_W-1:0] nxt;
   } alu_res_type;

endpackage

// ----- rtl/csid_mem.sv -----
// Entry store of the id set: one write port, one read port with registered data.
// Depends on csid_pkg for the depth and the entry width.
module csid_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [csid_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [csid_pkg::KEY_W-1:0]   wr_data,
   input  logic [csid_pkg::ADDR_W-1:0]  rd_addr,
   output logic [csid_pkg::KEY_W-1:0]   rd_data
);
   import csid_pkg::*;

   logic [KEY_W-1:0] mem [CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/csid_alu.sv -----
// Shared compare and increment unit used by both the scan and the shift steps.
// Depends on csid_pkg for widths and the result struct.
module csid_alu (
   input  logic [csid_pkg::KEY_W-1:0] rd_data,
   input  logic [csid_pkg::KEY_W-1:0] key,
   input  logic [csid_pkg::CNT_W-1:0] idx,
   input  logic [csid_pkg::CNT_W-1:0] occ,
   output csid_pkg::alu_res_type      res
);
   import csid_pkg::*;

   always_comb begin
      res.nxt    = idx + CNT_W'(1);
      res.hit    = (rd_data == key);
      res.at_end = (idx == occ);
      res.last   = (res.nxt == occ);
   end

endmodule

// ----- rtl/compacting_id_set_top.sv -----
// Compacting id set: ordered set of ids with append, lookup and compacting remove.
// A clear needs no scan; query and insert scan the entries in order up to the match or the
// end of the set, and a remove that finds its id then moves each entry above the match
// down one place. No new item is taken until the last one has loaded the result register.
// Reset clears the occupancy, the sequencer and the result valid flag; entries are not.
module compacting_id_set_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csid_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csid_pkg::rsp_type rsp_data
);
   import csid_pkg::*;

   // The sequencer drives one memory read port and one shared comparator.
   // SEARCH walks the held entries in order, one per cycle, since the entry
   // memory returns one registered word per cycle. SHIFT moves each later
   // entry down one place for a remove. FINISH commits the count and loads
   // the result register, waiting there if the previous result is not taken.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [KEY_W-1:0]  rd_data;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [KEY_W-1:0]  mem_wd;
   alu_res_type       alu_res;

   logic             fin_go;
   logic             append;
   logic [CNT_W-1:0] new_occ;
   rsp_type          result;

   csid_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csid_alu u_alu (
      .rd_data (rd_data),
      .key     (key_ff),
      .idx     (idx_ff),
      .occ     (occ_ff),
      .res     (alu_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   // The result register frees up either when empty or when taken this cycle.
   assign fin_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Outcome of the request, decided from the scan result and the count.
   always_comb begin
      append             = 1'b0;
      new_occ            = occ_ff;
      result.was_present = found_ff;
      result.status      = STATUS_DONE;
      unique case (op_ff)
         OP_QUERY: begin
            result.status = STATUS_DONE;
         end
         OP_INSERT: begin
            if (found_ff) begin
               result.status = STATUS_NO_CHANGE;
            end else if (occ_ff == CNT_W'(CAPACITY)) begin
               result.status = STATUS_FULL;
            end else begin
               append  = 1'b1;
               new_occ = occ_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               new_occ = occ_ff - CNT_W'(1);
            end else begin
               result.status = STATUS_NO_CHANGE;
            end
         end
         OP_CLEAR: begin
            result.was_present = 1'b0;
            new_occ            = '0;
         end
         default: begin
            result.status = STATUS_DONE;
         end
      endcase
      result.occupancy_out = OCC_OUT_W'(new_occ);
   end

   // Sequencer. The read issued in one cycle returns the entry at idx_ff in
   // the next, so outside IDLE the read address runs one entry ahead of idx_ff.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      wr_ptr_in = wr_ptr_ff;
      found_in  = found_ff;
      occ_in    = occ_ff;
      rd_addr   = alu_res.nxt[ADDR_W-1:0];
      mem_we    = 1'b0;
      mem_wa    = wr_ptr_ff[ADDR_W-1:0];
      mem_wd    = rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               op_in    = req_data.opcode;
               key_in   = req_data.key_id;
               idx_in   = '0;
               found_in = 1'b0;
               // A clear, or any lookup in an empty set, needs no scan.
               if (req_data.opcode == OP_CLEAR || occ_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (alu_res.hit) begin
               found_in = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  // The entry above the match is already being read.
                  wr_ptr_in = idx_ff;
                  idx_in    = alu_res.nxt;
                  state_in  = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (alu_res.last) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = alu_res.nxt;
            end
         end
         ST_SHIFT: begin
            // idx_ff names the entry now on the read data; it moves to wr_ptr_ff.
            if (alu_res.at_end) begin
               state_in = ST_FINISH;
            end else begin
               mem_we    = 1'b1;
               wr_ptr_in = idx_ff;
               idx_in    = alu_res.nxt;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               occ_in   = new_occ;
               state_in = ST_IDLE;
               if (append) begin
                  mem_we = 1'b1;
                  mem_wa = occ_ff[ADDR_W-1:0];
                  mem_wd = key_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      wr_ptr_ff <= wr_ptr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The count never passes the capacity.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   // The count changes only when a request finishes.
   a_occ_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(fin_go)) |-> $stable(occ_ff))
      else $error("occupancy changed outside a finish");

   // Entries shift only for a remove that found its id.
   a_shift_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (op_ff == OP_REMOVE && found_ff))
      else $error("shift without a matched remove");

   // A clear always reports an empty set.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (fin_go && op_ff == OP_CLEAR) |=> (rsp_valid && rsp_data.occupancy_out == '0))
      else $error("clear did not report an empty set");

endmodule

// ----- bench/compacting_id_set_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for compacting_id_set_top: a scoreboard class predicts every result.
// Depends on csid_pkg and the compacting_id_set_top RTL only.
module compacting_id_set_top_tb;

   import csid_pkg::*;

   // Shape of the random part. A fill-heavy mix pushes the set to capacity and
   // beyond. A drain-heavy mix removes held ids at random positions. Noise
   // spreads opcodes evenly and draws most keys at random.
   typedef enum {
      MIX_FILL,
      MIX_DRAIN,
      MIX_MIXED,
      MIX_NOISE
   } mix_mode_type;

   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned MAX_GAP      = 18;
   localparam int unsigned HOLD_AT      = 400;   // Result count at which the receiver holds off.
   localparam int unsigned HOLD_CYCLES  = 300;
   // A remove that finds its id in a full set takes the longest of any item from acceptance
   // to result. The limit allows for the long hold-off.
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned POOL_SIZE     = 72;
   localparam int unsigned REPORT_LIMIT  = 10;

   // The scoreboard keeps a model of the set and a queue of the results still owed by the block.
   class id_set_scoreboard;
      logic [KEY_W-1:0] held_ids [CAPACITY];
      int unsigned      held_count;
      rsp_type          owed_results [$];
      int unsigned      mismatch_count;

      function new();
         held_count     = 0;
         mismatch_count = 0;
      endfunction

      // Applies one accepted item to the model and queues the result it must produce.
      function void note_request(req_type req);
         rsp_type expected;
         int      pos;
         int      i;
         expected        = '0;
         expected.status = STATUS_DONE;
         pos             = -1;
         if (req.opcode == OP_CLEAR) begin
            held_count = 0;
         end else begin
            for (i = 0; i < int'(held_count); i++) begin
               if (pos < 0 && held_ids[i] == req.key_id) begin
                  pos = i;
               end
            end
            expected.was_present = (pos >= 0);
            if (req.opcode == OP_INSERT) begin
               if (pos >= 0) begin
                  expected.status = STATUS_NO_CHANGE;
               end else if (held_count >= CAPACITY) begin
                  expected.status = STATUS_FULL;
               end else begin
                  held_ids[held_count] = req.key_id;
                  held_count++;
               end
            end else if (req.opcode == OP_REMOVE) begin
               if (pos < 0) begin
                  expected.status = STATUS_NO_CHANGE;
               end else begin
                  for (i = pos; i + 1 < int'(held_count); i++) begin
                     held_ids[i] = held_ids[i + 1];
                  end
                  held_count--;
               end
            end
         end
         expected.occupancy_out = OCC_OUT_W'(held_count);
         owed_results.push_back(expected);
      endfunction

      // Compares one accepted result with the oldest owed result.
      function void check_result(rsp_type actual);
         rsp_type expected;
         if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: result with nothing owed: was_present=%0d status=%0d occ=%0d",
                        $time, actual.was_present, actual.status, actual.occupancy_out);
            end
         end else begin
            expected = owed_results.pop_front();
            if (actual.was_present !== expected.was_present || actual.status !== expected.status
                || actual.occupancy_out !== expected.occupancy_out) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: expected was_present=%0d status=%0d occ=%0d, got %0d %0d %0d",
                           $time, expected.was_present, expected.status,
                           expected.occupancy_out, actual.was_present, actual.status,
                           actual.occupancy_out);
               end
            end
         end
      endfunction

      function int unsigned outstanding();
         return owed_results.size();
      endfunction

      function logic [KEY_W-1:0] any_held_id();
         return held_ids[$urandom_range(0, held_count - 1)];
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   id_set_scoreboard sb = new();

   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   bit               sender_calm = 1'b0;
   int unsigned      idle_cycles = 0;

   compacting_id_set_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Reset is held from the start and then released for the rest of the run.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Both handshakes are sampled at the rising edge, where every input still holds the
   // value driven on the previous edge. An item is noted before a result is checked, so
   // a result and a new item meeting at one edge are handled in the right order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
         end
      end
   end

   // The watchdog ends a run in which neither side has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item after a random gap and returns at the edge that accepts it. Valid is
   // left high, so the caller either offers the next item in the same time step or lowers
   // valid itself. A gap of zero keeps valid high from one item to the next.
   task automatic send_item(input logic [1:0] opcode, input logic [KEY_W-1:0] key_id);
      int unsigned gap;
      req_type     item;
      gap         = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      item.opcode = opcode;
      item.key_id = key_id;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Withdraws valid and waits until the block has delivered every owed result. The first
   // edge lets the monitor note the item that was accepted just now.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_opcode(mix_mode_type mode);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      unique case (mode)
         MIX_FILL: begin
            return (roll < 2) ? OP_CLEAR : (roll < 80) ? OP_INSERT
                 : (roll < 90) ? OP_QUERY : OP_REMOVE;
         end
         MIX_DRAIN: begin
            return (roll < 2) ? OP_CLEAR : (roll < 15) ? OP_INSERT
                 : (roll < 35) ? OP_QUERY : OP_REMOVE;
         end
         MIX_MIXED: begin
            return (roll < 4) ? OP_CLEAR : (roll < 45) ? OP_INSERT
                 : (roll < 70) ? OP_QUERY : OP_REMOVE;
         end
         default: begin
            return 2'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // Outside noise, keys come mostly from ids the set holds and from a small pool, so inserts collide
   // and removes hit. The rest are fully random and reach every bit of the field.
   function automatic logic [KEY_W-1:0] pick_key(mix_mode_type mode);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (mode == MIX_NOISE) begin
         return (roll < 70) ? KEY_W'($urandom) : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      if (roll < 45 && sb.held_count > 0) begin
         return sb.any_held_id();
      end
      if (roll < 85) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return KEY_W'($urandom);
   endfunction

   // The receiver draws a stall before each result. Some stretches of fifty results take
   // no stall at all, and once it holds off for a long stretch while the sender keeps
   // offering, so the result register fills and the block stops taking items.
   initial begin
      int unsigned stall;
      int unsigned taken;
      bit          calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 50 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         if (taken == HOLD_AT) begin
            stall = HOLD_CYCLES;
         end else begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      int unsigned  items_sent;
      int unsigned  segment;
      int unsigned  segment_len;
      int unsigned  k;
      mix_mode_type mode;
      while (reset) @(posedge clock);

      // Directed part: queries and removes on an empty set, the key extremes, a duplicate
      // insert, removes of the first, a middle and the last entry, an absent remove, and
      // clears of a held set and of an empty one with keys that must be ignored.
      send_item(OP_QUERY,  16'h1234);
      send_item(OP_REMOVE, 16'h1234);
      send_item(OP_INSERT, 16'h0000);
      send_item(OP_INSERT, 16'hFFFF);
      send_item(OP_INSERT, 16'h1234);
      send_item(OP_INSERT, 16'hFFFF);
      send_item(OP_QUERY,  16'h0000);
      send_item(OP_QUERY,  16'hFFFE);
      send_item(OP_INSERT, 16'hAAAA);
      send_item(OP_INSERT, 16'h5555);
      send_item(OP_REMOVE, 16'hFFFF);
      send_item(OP_REMOVE, 16'h0000);
      send_item(OP_REMOVE, 16'h5555);
      send_item(OP_REMOVE, 16'h5555);
      send_item(OP_CLEAR,  16'hFFFF);
      send_item(OP_QUERY,  16'h1234);
      send_item(OP_INSERT, 16'h8001);
      send_item(OP_CLEAR,  16'h0000);
      send_item(OP_CLEAR,  16'h7FFE);
      // The sender pauses here until the block has answered every item so far.
      wait_until_drained();

      // Random part in segments of one mix each. The first segment is fill-heavy, so the
      // set reaches capacity early and inserts into a full set are covered.
      items_sent = 0;
      segment    = 0;
      while (items_sent < RANDOM_ITEMS) begin
         mode        = (segment == 0) ? MIX_FILL : mix_mode_type'($urandom_range(0, 3));
         segment_len = (mode == MIX_FILL) ? $urandom_range(100, 160) : $urandom_range(40, 140);
         sender_calm = (segment != 0) && ($urandom_range(0, 3) == 0);
         for (k = 0; k < POOL_SIZE; k++) begin
            key_pool[k] = KEY_W'($urandom);
         end
         for (k = 0; k < segment_len && items_sent < RANDOM_ITEMS; k++) begin
            send_item(pick_opcode(mode), pick_key(mode));
            items_sent++;
         end
         segment++;
      end

      // Let the last results arrive, then give a stray result time to show up.
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/csid_pkg.sv
rtl/csid_mem.sv
rtl/csid_alu.sv
rtl/compacting_id_set_top.sv
bench/compacting_id_set_top_tb.sv
